[rtl/core/arb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arb_pkg
// Shared types, codes and helpers for the ASCII register bus slave.
// ----------------------------------------------------------------------------
package arb_pkg;

    localparam int REG_COUNT = 64;
    localparam int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    localparam logic [1:0] FUNC_LINE  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [7:0] CFG_DEVICE_ID  = 8'd0;
    localparam logic [7:0] CFG_WRITE_CODE = 8'd1;
    localparam logic [7:0] CFG_REPLY_CODE = 8'd2;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         line_byte;
        logic [5:0]         local_addr;
        logic signed [15:0] local_data;
    } t_in;

    typedef struct packed {
        logic               is_local;
        logic [7:0]         tx_byte;
        logic signed [15:0] read_data;
        logic [5:0]         last_address;
        logic               end_of_run;
    } t_out;

    typedef struct packed {
        logic        start;
        logic        take;
        logic [15:0] value;
    } t_dig_ctl;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] char_out;
    } t_dig_sts;

    // Clamp a 16-bit two's complement value into the register range.
    function automatic logic [IDX_W-1:0] clamp_index(input logic [15:0] v);
        logic [IDX_W-1:0] r;
        if (v[15]) begin
            r = '0;
        end else if (v > 16'(REG_COUNT - 1)) begin
            r = IDX_W'(REG_COUNT - 1);
        end else begin
            r = v[IDX_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/arb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module arb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/arb_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arb_digits
// Signed decimal text serializer: sign, digits, CR, LF, one char per take.
// ----------------------------------------------------------------------------
module arb_digits
    import arb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dig_ctl i_ctl,
    output t_dig_sts o_sts
);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_SIGN = 3'd1;
    localparam logic [2:0] D_DIG  = 3'd2;
    localparam logic [2:0] D_PUT  = 3'd3;
    localparam logic [2:0] D_CR   = 3'd4;
    localparam logic [2:0] D_LF   = 3'd5;

    localparam logic [15:0] POW [5] = '{16'd10000, 16'd1000, 16'd100, 16'd10, 16'd1};

    logic [2:0]  r_state, n_state;
    logic [15:0] r_mag, n_mag;
    logic [2:0]  r_idx, n_idx;
    logic [3:0]  r_digit, n_digit;
    logic        r_started, n_started;

    logic        ge;
    logic [15:0] pw;

    // shared compare and subtract against the current power of ten
    assign pw = POW[r_idx];
    assign ge = (r_mag >= pw);

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_idx     = r_idx;
        n_digit   = r_digit;
        n_started = r_started;
        if (i_ctl.start) begin
            n_mag     = i_ctl.value[15] ? (16'd0 - i_ctl.value) : i_ctl.value;
            n_idx     = '0;
            n_digit   = '0;
            n_started = 1'b0;
            n_state   = i_ctl.value[15] ? D_SIGN : D_DIG;
        end else begin
            unique case (r_state)
                D_SIGN: begin
                    if (i_ctl.take) n_state = D_DIG;
                end
                D_DIG: begin
                    if (ge) begin
                        n_mag   = r_mag - pw;
                        n_digit = r_digit + 4'd1;
                    end else if (r_digit != 4'd0 || r_started || r_idx == 3'd4) begin
                        n_state = D_PUT;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
                D_PUT: begin
                    if (i_ctl.take) begin
                        n_started = 1'b1;
                        n_digit   = '0;
                        if (r_idx == 3'd4) begin
                            n_state = D_CR;
                        end else begin
                            n_idx   = r_idx + 3'd1;
                            n_state = D_DIG;
                        end
                    end
                end
                D_CR: begin
                    if (i_ctl.take) n_state = D_LF;
                end
                D_LF: begin
                    if (i_ctl.take) n_state = D_IDLE;
                end
                default: n_state = D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mag     <= n_mag;
        r_idx     <= n_idx;
        r_digit   <= n_digit;
        r_started <= n_started;
    end

    always_comb begin
        o_sts.valid    = 1'b0;
        o_sts.last     = 1'b0;
        o_sts.char_out = CH_LF;
        unique case (r_state)
            D_SIGN: begin
                o_sts.valid    = 1'b1;
                o_sts.char_out = CH_MINUS;
            end
            D_PUT: begin
                o_sts.valid    = 1'b1;
                o_sts.char_out = CH_ZERO + {4'd0, r_digit};
            end
            D_CR: begin
                o_sts.valid    = 1'b1;
                o_sts.char_out = CH_CR;
            end
            D_LF: begin
                o_sts.valid = 1'b1;
                o_sts.last  = 1'b1;
            end
            default: o_sts.valid = 1'b0;
        endcase
    end

endmodule

[rtl/core/ascii_register_bus_slave.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_register_bus_slave
// Slave of an ASCII register bus with a local read and write port.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one word per line byte,
// local read or local write. Output channel (o_out_valid / i_out_ready)
// carries reply bytes and local read answers through one output register.
// Configuration writes (device id, write code, reply code) are always accepted.
// Line bytes and local writes are taken in the idle state; a local read
// reads the bank, then waits for the output register. An accepted frame is
// answered with '&' and five decimal numbers, each with CRLF; each digit
// is found in the shared compare-subtract unit. No input is taken while a
// local read or a reply is in flight.
// Reset clears the parser, the last address and the register bank: each
// bank entry has a valid bit, so an unwritten entry reads as zero at once.
// A stalled receiver holds the output register; the block waits with it.
// ----------------------------------------------------------------------------
module ascii_register_bus_slave
    import arb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LRD  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_RW   = 3'd3;
    localparam logic [2:0] S_AMP  = 3'd4;
    localparam logic [2:0] S_NUM  = 3'd5;

    // configuration
    logic [7:0] r_dev_id, r_wr_code, r_rep_code;

    // control
    logic [2:0]  r_state, n_state;
    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic        r_minus, n_minus;
    logic        r_digits, n_digits;
    logic [15:0] r_fld [4];
    logic [15:0] r_sum, n_sum;
    logic [IDX_W-1:0] r_last, n_last;
    logic [2:0]  r_k, n_k;
    logic [15:0] r_reg, r_rsum, r_rbase;
    logic [REG_COUNT-1:0] r_vld;
    logic        r_rvld;

    // output register
    logic r_ov;
    t_out r_out, n_out;
    logic load;
    logic slot_free;

    // bank access
    logic             we, re;
    logic [IDX_W-1:0] waddr, raddr;
    logic [15:0]      wdata, rdata, rval;

    // number serializer
    t_dig_ctl dctl;
    t_dig_sts dsts;
    logic [15:0] sel_val;

    logic        accept, line_in;
    logic [7:0]  b;
    logic [15:0] value;
    logic        fld_we;
    logic [1:0]  fld_idx;
    logic        hit;
    logic [IDX_W-1:0] faddr, laddr;
    logic [15:0] last16;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign line_in     = accept && (i_in.func == FUNC_LINE);
    assign b           = i_in.line_byte;
    assign slot_free   = !r_ov || i_out_ready;
    assign value       = r_minus ? (16'd0 - r_acc) : r_acc;
    assign faddr       = clamp_index(r_fld[2]);
    assign laddr       = clamp_index(16'(i_in.local_addr));
    assign last16      = 16'(r_last);
    assign rval        = r_rvld ? rdata : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id   <= 8'd0;
            r_wr_code  <= 8'd1;
            r_rep_code <= 8'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ID:  r_dev_id   <= i_cfg_data;
                CFG_WRITE_CODE: r_wr_code  <= i_cfg_data;
                CFG_REPLY_CODE: r_rep_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parser and sequencer
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_minus  = r_minus;
        n_digits = r_digits;
        n_sum    = r_sum;
        n_last   = r_last;
        n_k      = r_k;
        fld_we   = 1'b0;
        fld_idx  = r_phase[1:0] - 2'd1;
        hit      = 1'b0;
        we       = 1'b0;
        waddr    = laddr;
        wdata    = i_in.local_data;
        re       = 1'b0;
        raddr    = laddr;
        load     = 1'b0;
        n_out    = r_out;
        dctl.start = 1'b0;
        dctl.take  = 1'b0;
        dctl.value = sel_val;

        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in.func == FUNC_READ) begin
                    re      = 1'b1;
                    n_state = S_LRD;
                end else if (accept && i_in.func == FUNC_WRITE) begin
                    we = 1'b1;
                end else if (line_in) begin
                    if (r_phase == 3'd0) begin
                        if (b == CH_HASH) begin
                            n_phase  = 3'd1;
                            n_acc    = '0;
                            n_minus  = 1'b0;
                            n_digits = 1'b0;
                        end
                    end else if (b >= CH_ZERO && b <= CH_NINE) begin
                        n_acc    = (r_acc << 3) + (r_acc << 1) + 16'(b - CH_ZERO);
                        n_digits = 1'b1;
                    end else if (b == CH_MINUS) begin
                        n_minus = 1'b1;
                    end else if (r_digits || r_minus) begin
                        n_acc    = '0;
                        n_minus  = 1'b0;
                        n_digits = 1'b0;
                        if (r_phase < 3'd5) begin
                            fld_we  = 1'b1;
                            n_sum   = (r_phase == 3'd1) ? value : r_sum + value;
                            n_phase = r_phase + 3'd1;
                        end else begin
                            n_phase = (b == CH_HASH) ? 3'd1 : 3'd0;
                            hit = (r_fld[0] == {8'd0, r_dev_id}) && (r_sum == value);
                            if (hit) begin
                                n_last  = faddr;
                                we      = (r_fld[1] == {8'd0, r_wr_code});
                                waddr   = faddr;
                                wdata   = r_fld[3];
                                n_state = S_RD;
                            end
                        end
                    end
                end
            end
            S_LRD: begin
                if (slot_free) begin
                    load               = 1'b1;
                    n_out.is_local     = 1'b1;
                    n_out.tx_byte      = 8'd0;
                    n_out.read_data    = rval;
                    n_out.last_address = last16[5:0];
                    n_out.end_of_run   = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_RD: begin
                re      = 1'b1;
                raddr   = r_last;
                n_state = S_RW;
            end
            S_RW: begin
                n_state = S_AMP;
            end
            S_AMP: begin
                if (slot_free) begin
                    load               = 1'b1;
                    n_out.is_local     = 1'b0;
                    n_out.tx_byte      = CH_AMP;
                    n_out.read_data    = 16'd0;
                    n_out.last_address = last16[5:0];
                    n_out.end_of_run   = 1'b0;
                    n_k                = 3'd0;
                    dctl.start         = 1'b1;
                    n_state            = S_NUM;
                end
            end
            S_NUM: begin
                if (slot_free && dsts.valid) begin
                    load               = 1'b1;
                    dctl.take          = 1'b1;
                    n_out.is_local     = 1'b0;
                    n_out.tx_byte      = dsts.char_out;
                    n_out.read_data    = 16'd0;
                    n_out.last_address = last16[5:0];
                    n_out.end_of_run   = dsts.last && (r_k == 3'd4);
                    if (dsts.last) begin
                        if (r_k == 3'd4) begin
                            n_state = S_IDLE;
                        end else begin
                            n_k        = r_k + 3'd1;
                            dctl.start = 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // value of the next reply number
    always_comb begin
        unique case (n_k)
            3'd0:    sel_val = r_fld[0];
            3'd1:    sel_val = {8'd0, r_rep_code};
            3'd2:    sel_val = last16;
            3'd3:    sel_val = r_reg;
            default: sel_val = r_rsum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 3'd0;
            r_acc    <= '0;
            r_minus  <= 1'b0;
            r_digits <= 1'b0;
            r_sum    <= '0;
            r_last   <= '0;
            r_k      <= '0;
            r_vld    <= '0;
            r_ov     <= 1'b0;
            for (int i = 0; i < 4; i++) r_fld[i] <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_minus  <= n_minus;
            r_digits <= n_digits;
            r_sum    <= n_sum;
            r_last   <= n_last;
            r_k      <= n_k;
            if (we) r_vld[waddr] <= 1'b1;
            if (fld_we) r_fld[fld_idx] <= value;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (load) r_out <= n_out;
        if (re) r_rvld <= r_vld[raddr];
        // reply sum: base of id, reply code and address, then add the register
        if (hit) r_rbase <= r_fld[0] + {8'd0, r_rep_code} + 16'(faddr);
        if (r_state == S_RW) begin
            r_reg  <= rval;
            r_rsum <= r_rbase + rval;
        end
    end

    arb_ram #(
        .WIDTH (16),
        .DEPTH (REG_COUNT)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    arb_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dctl),
        .o_sts   (dsts)
    );

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_eor_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.is_local && o_out.end_of_run) |-> (o_out.tx_byte == CH_LF))
        else $error("reply run does not end in LF");
    a_local_ans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.is_local) |-> (o_out.end_of_run && o_out.tx_byte == 8'd0))
        else $error("malformed local read answer");
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 3'd5)
        else $error("parse phase out of range");
    a_num_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NUM && !dsts.valid) |=> (r_state == S_NUM))
        else $error("reply left before number done");
`endif

endmodule
